// ----- hdl/trapezoid_ramp_step_3d_assert.svh -----
// Assertion macros shared by the ramp block.
`ifndef TRAPEZOID_RAMP_STEP_3D_ASSERT_SVH
`define TRAPEZOID_RAMP_STEP_3D_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TRS3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trs3 assertion failed");

// Next-cycle implication, checked outside reset.
`define TRS3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trs3 assertion failed");

`endif

// ----- hdl/trs3_pkg.sv -----
`timescale 1ns / 1ps
package trs3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [30:0] U31 = 31'h7FFF_FFFF;

  localparam logic [30:0] ACCEL_RST  = 31'd65536;
  localparam logic [30:0] DECEL_RST  = 31'd65536;
  localparam logic [30:0] CRUISE_RST = 31'd65536;
  localparam logic [30:0] DMAX_RST   = 31'd0;
  localparam logic [30:0] TOL_RST    = 31'd6554;
  localparam logic [15:0] LEAD_RST   = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL,
    CFG_DECEL,
    CFG_CRUISE,
    CFG_DECEL_MAX,
    CFG_PROG_TOL,
    CFG_LEAD
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [15:0] rate;
    logic [15:0]        tick_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] stop_x;
    logic signed [31:0] stop_y;
    logic signed [31:0] stop_z;
    logic [30:0]        speed;
    logic [30:0]        remaining;
    logic [30:0]        stuck_time;
  } out_item_t;

  typedef struct packed {
    logic [30:0] accel_std;
    logic [30:0] decel_std;
    logic [30:0] cruise_std;
    logic [30:0] decel_max;
    logic [30:0] progress_tol;
    logic [15:0] lead_factor;
  } cfg_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] y;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_SQ, S_DIST, S_DIR, S_PROG, S_RR, S_AC, S_DC, S_VM,
    S_DOT, S_INC, S_VEL, S_VSQ, S_SP, S_BRK, S_BRKR, S_CAP, S_DEC, S_SCL,
    S_SCD, S_LEAD1, S_LEAD2, S_STP, S_OUT
  } seq_state_t;

endpackage

// ----- hdl/trs3_alu.sv -----
`timescale 1ns / 1ps
`include "trapezoid_ramp_step_3d_assert.svh"
module trs3_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  trs3_pkg::alu_req_t req_i,
  output trs3_pkg::alu_rsp_t rsp_o
);

  localparam logic [6:0] MUL_LAST  = 7'd31;
  localparam logic [6:0] DIV_LAST  = 7'd63;
  localparam logic [6:0] SQRT_LAST = 7'd31;
  localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  trs3_pkg::alu_op_t op_r, op_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic [64:0]       acc_r, acc_nxt;
  logic [63:0]       x_r, x_nxt;
  logic [63:0]       z_r, z_nxt;

  logic [64:0] shl;
  logic        ge;
  logic [63:0] rt_sum;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    z_nxt    = z_r;
    shl      = {acc_r[63:0], x_r[63]};
    ge       = shl >= {1'b0, z_r};
    rt_sum   = acc_r[63:0] + z_r;
    if (!busy_r) begin
      if (req_i.start) begin
        busy_nxt = 1'b1;
        op_nxt   = req_i.op;
        x_nxt    = req_i.a;
        acc_nxt  = '0;
        unique case (req_i.op)
          trs3_pkg::ALU_MUL: begin
            z_nxt   = req_i.b;
            cnt_nxt = MUL_LAST;
          end
          trs3_pkg::ALU_DIV: begin
            z_nxt   = req_i.b;
            cnt_nxt = DIV_LAST;
          end
          trs3_pkg::ALU_SQRT: begin
            z_nxt   = SQRT_BIT0;
            cnt_nxt = SQRT_LAST;
          end
          default: begin
            z_nxt   = req_i.b;
            cnt_nxt = MUL_LAST;
          end
        endcase
      end
    end else begin
      unique case (op_r)
        trs3_pkg::ALU_MUL: begin
          if (z_r[0]) begin
            acc_nxt = acc_r + {1'b0, x_r};
          end
          x_nxt = {x_r[62:0], 1'b0};
          z_nxt = {1'b0, z_r[63:1]};
        end
        trs3_pkg::ALU_DIV: begin
          acc_nxt = ge ? (shl - {1'b0, z_r}) : shl;
          x_nxt   = {x_r[62:0], ge};
        end
        trs3_pkg::ALU_SQRT: begin
          if (x_r >= rt_sum) begin
            x_nxt   = x_r - rt_sum;
            acc_nxt = {1'b0, {1'b0, acc_r[63:1]} + z_r};
          end else begin
            acc_nxt = {2'b00, acc_r[63:1]};
          end
          z_nxt = {2'b00, z_r[63:2]};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    z_r   <= z_nxt;
  end

  assign rsp_o.busy = busy_r;
  assign rsp_o.done = done_r;
  assign rsp_o.y    = (op_r == trs3_pkg::ALU_DIV) ? x_r : acc_r[63:0];

  `TRS3_ASSERT_NXT(a_alu_runs, clk, rst_n, busy_r && cnt_r != 7'd0, busy_r)
  `TRS3_ASSERT_IMP(a_alu_done_idle, clk, rst_n, done_r, !busy_r)

endmodule

// ----- hdl/trs3_seq.sv -----
`timescale 1ns / 1ps
`include "trapezoid_ramp_step_3d_assert.svh"
module trs3_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  trs3_pkg::in_item_t  item_i,
  input  trs3_pkg::cfg_t      cfg_i,
  input  logic                out_free_i,
  output logic                idle_o,
  output logic                done_o,
  output trs3_pkg::out_item_t result_o
);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(x);
    end
    return r;
  endfunction

  function automatic logic [30:0] sat_u31(input logic [63:0] x);
    return (x > 64'h7FFF_FFFF) ? trs3_pkg::U31 : x[30:0];
  endfunction

  trs3_pkg::seq_state_t state_r, state_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] pos_nxt [3];
  logic signed [33:0] dlt_r [3];
  logic signed [33:0] dlt_nxt [3];
  logic signed [15:0] rt_r, rt_nxt;
  logic [15:0]        tick_r, tick_nxt;
  logic               shf_r, shf_nxt;
  logic [63:0]        sum_r, sum_nxt;
  logic [32:0]        dist_r, dist_nxt;
  logic signed [18:0] dir_r [3];
  logic signed [18:0] dir_nxt [3];
  logic [31:0]        best_r, best_nxt;
  logic [30:0]        stuck_r, stuck_nxt;
  logic               frozen_r, frozen_nxt;
  logic signed [31:0] hold_r [3];
  logic signed [31:0] hold_nxt [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] vel_nxt [3];
  logic [30:0]        acc_r, acc_nxt;
  logic [30:0]        dc_r, dc_nxt;
  logic [31:0]        vmax_r, vmax_nxt;
  logic signed [63:0] dot_r, dot_nxt;
  logic [30:0]        inc_r, inc_nxt;
  logic [31:0]        sp_r, sp_nxt;
  logic [63:0]        tmp_r, tmp_nxt;
  logic [32:0]        amt_r, amt_nxt;
  logic signed [31:0] stop_r [3];
  logic signed [31:0] stop_nxt [3];

  trs3_pkg::alu_req_t alu_req;
  trs3_pkg::alu_rsp_t alu_rsp;

  logic signed [31:0] ipos [3];
  logic signed [31:0] igoal [3];
  logic signed [31:0] gsel [3];
  logic [33:0]        dabs [3];
  logic [33:0]        dmag;
  logic [31:0]        vmag;
  logic [18:0]        dirmag;
  logic [15:0]        rtmag;
  logic               go;
  logic               fin;
  logic               prod_neg;
  logic signed [63:0] sprod;
  logic [31:0]        dsat;
  logic [31:0]        tickf;
  logic [31:0]        stuck_sum;
  logic [31:0]        dec;
  logic [31:0]        v2;
  logic [31:0]        quo;
  logic [63:0]        lead_t;
  logic               last;

  trs3_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_comb begin
    ipos[0]  = item_i.pos_x;
    ipos[1]  = item_i.pos_y;
    ipos[2]  = item_i.pos_z;
    igoal[0] = item_i.goal_x;
    igoal[1] = item_i.goal_y;
    igoal[2] = item_i.goal_z;
    for (int i = 0; i < 3; i++) begin
      dabs[i] = dlt_r[i][33] ? 34'(-dlt_r[i]) : 34'(dlt_r[i]);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    pos_nxt    = pos_r;
    dlt_nxt    = dlt_r;
    rt_nxt     = rt_r;
    tick_nxt   = tick_r;
    shf_nxt    = shf_r;
    sum_nxt    = sum_r;
    dist_nxt   = dist_r;
    dir_nxt    = dir_r;
    best_nxt   = best_r;
    stuck_nxt  = stuck_r;
    frozen_nxt = frozen_r;
    hold_nxt   = hold_r;
    vel_nxt    = vel_r;
    acc_nxt    = acc_r;
    dc_nxt     = dc_r;
    vmax_nxt   = vmax_r;
    dot_nxt    = dot_r;
    inc_nxt    = inc_r;
    sp_nxt     = sp_r;
    tmp_nxt    = tmp_r;
    amt_nxt    = amt_r;
    stop_nxt   = stop_r;
    gsel       = igoal;
    go         = 1'b0;
    prod_neg   = 1'b0;
    alu_req    = '0;
    alu_req.op = trs3_pkg::ALU_MUL;
    done_o     = 1'b0;

    fin    = pend_r && alu_rsp.done;
    last   = (idx_r == 2'd2);
    dmag   = dabs[idx_r];
    vmag   = vel_r[idx_r][31] ? (~vel_r[idx_r] + 32'sd1) : vel_r[idx_r];
    dirmag = dir_r[idx_r][18] ? 19'(-dir_r[idx_r]) : 19'(dir_r[idx_r]);
    rtmag  = rt_r[15] ? 16'(-rt_r) : 16'(rt_r);
    dsat   = dist_r[32] ? 32'hFFFF_FFFF : dist_r[31:0];
    tickf  = 32'(tick_r) << (trs3_pkg::FRAC_BITS - 16);
    stuck_sum = 32'(stuck_r) + tickf;
    dec    = 32'(alu_rsp.y >> 16);
    v2     = (sp_r > dec) ? (sp_r - dec) : 32'd0;
    quo    = alu_rsp.y[31:0];
    lead_t = alu_rsp.y >> 8;

    unique case (state_r)
      trs3_pkg::S_IDLE: begin
        if (start_i) begin
          pos_nxt  = ipos;
          rt_nxt   = item_i.rate;
          tick_nxt = item_i.tick_time;
          if (item_i.rate != 16'sd0) begin
            frozen_nxt = 1'b0;
          end else begin
            if (!frozen_r) begin
              hold_nxt = ipos;
            end
            gsel       = frozen_r ? hold_r : ipos;
            frozen_nxt = 1'b1;
          end
          for (int i = 0; i < 3; i++) begin
            dlt_nxt[i] = 34'(gsel[i]) - 34'(ipos[i]);
          end
          state_nxt = trs3_pkg::S_PREP;
        end
      end
      trs3_pkg::S_PREP: begin
        shf_nxt   = (|dabs[0][33:31]) | (|dabs[1][33:31]) | (|dabs[2][33:31]);
        sum_nxt   = '0;
        idx_nxt   = 2'd0;
        state_nxt = trs3_pkg::S_SQ;
      end
      trs3_pkg::S_SQ: begin
        go = 1'b1;
        alu_req.a = 64'(dmag >> shf_r);
        alu_req.b = 64'(dmag >> shf_r);
        if (fin) begin
          sum_nxt = sum_r + alu_rsp.y;
          idx_nxt = last ? 2'd0 : idx_r + 2'd1;
          if (last) begin
            state_nxt = trs3_pkg::S_DIST;
          end
        end
      end
      trs3_pkg::S_DIST: begin
        go = 1'b1;
        alu_req.op = trs3_pkg::ALU_SQRT;
        alu_req.a  = sum_r;
        if (fin) begin
          dist_nxt  = 33'(alu_rsp.y[31:0]) << shf_r;
          idx_nxt   = 2'd0;
          state_nxt = trs3_pkg::S_DIR;
        end
      end
      trs3_pkg::S_DIR: begin
        alu_req.op = trs3_pkg::ALU_DIV;
        alu_req.a  = 64'(dmag) << trs3_pkg::FRAC_BITS;
        alu_req.b  = 64'(dist_r);
        if (dist_r == 33'd0 || fin) begin
          if (dist_r == 33'd0) begin
            dir_nxt[idx_r] = '0;
          end else begin
            dir_nxt[idx_r] = dlt_r[idx_r][33] ? -$signed(alu_rsp.y[18:0])
                                              : $signed(alu_rsp.y[18:0]);
          end
          idx_nxt = last ? 2'd0 : idx_r + 2'd1;
          if (last) begin
            state_nxt = trs3_pkg::S_PROG;
          end
        end else begin
          go = 1'b1;
        end
      end
      trs3_pkg::S_PROG: begin
        if (best_r > dsat && (best_r - dsat) > 32'(cfg_i.progress_tol)) begin
          best_nxt  = dsat;
          stuck_nxt = '0;
        end else begin
          best_nxt  = (best_r > dsat) ? best_r : dsat;
          stuck_nxt = stuck_sum[31] ? trs3_pkg::U31 : stuck_sum[30:0];
        end
        if (rt_r < 16'sd0) begin
          acc_nxt   = cfg_i.accel_std;
          dc_nxt    = cfg_i.decel_std;
          state_nxt = trs3_pkg::S_VM;
        end else begin
          state_nxt = trs3_pkg::S_RR;
        end
      end
      trs3_pkg::S_RR: begin
        go = 1'b1;
        alu_req.a = 64'(rtmag);
        alu_req.b = 64'(rtmag);
        if (fin) begin
          tmp_nxt   = alu_rsp.y;
          state_nxt = trs3_pkg::S_AC;
        end
      end
      trs3_pkg::S_AC: begin
        go = 1'b1;
        alu_req.a = tmp_r;
        alu_req.b = 64'(cfg_i.accel_std);
        if (fin) begin
          acc_nxt   = sat_u31(alu_rsp.y >> 24);
          state_nxt = trs3_pkg::S_DC;
        end
      end
      trs3_pkg::S_DC: begin
        go = 1'b1;
        alu_req.a = tmp_r;
        alu_req.b = 64'(cfg_i.decel_std);
        if (fin) begin
          dc_nxt    = sat_u31(alu_rsp.y >> 24);
          state_nxt = trs3_pkg::S_VM;
        end
      end
      trs3_pkg::S_VM: begin
        go = 1'b1;
        alu_req.a = 64'(rtmag);
        alu_req.b = 64'(cfg_i.cruise_std);
        if (fin) begin
          vmax_nxt  = 32'(sat_u31(alu_rsp.y >> 12));
          dot_nxt   = '0;
          idx_nxt   = 2'd0;
          state_nxt = trs3_pkg::S_DOT;
        end
      end
      trs3_pkg::S_DOT: begin
        go = 1'b1;
        alu_req.a = 64'(vmag);
        alu_req.b = 64'(dirmag);
        prod_neg  = dir_r[idx_r][18] ^ vel_r[idx_r][31];
        if (fin) begin
          dot_nxt = dot_r + sprod;
          idx_nxt = last ? 2'd0 : idx_r + 2'd1;
          if (last) begin
            state_nxt = trs3_pkg::S_INC;
          end
        end
      end
      trs3_pkg::S_INC: begin
        go = 1'b1;
        alu_req.a = 64'((dot_r < 64'sd0) ? dc_r : acc_r);
        alu_req.b = 64'(tick_r);
        if (fin) begin
          inc_nxt   = 31'(alu_rsp.y >> 16);
          sum_nxt   = '0;
          idx_nxt   = 2'd0;
          state_nxt = trs3_pkg::S_VEL;
        end
      end
      trs3_pkg::S_VEL: begin
        go = 1'b1;
        alu_req.a = 64'(inc_r);
        alu_req.b = 64'(dirmag);
        prod_neg  = dir_r[idx_r][18];
        if (fin) begin
          vel_nxt[idx_r] = sat32(64'(vel_r[idx_r]) + (sprod >>> trs3_pkg::FRAC_BITS));
          state_nxt      = trs3_pkg::S_VSQ;
        end
      end
      trs3_pkg::S_VSQ: begin
        go = 1'b1;
        alu_req.a = 64'(vmag);
        alu_req.b = 64'(vmag);
        if (fin) begin
          sum_nxt   = sum_r + alu_rsp.y;
          idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
          state_nxt = last ? trs3_pkg::S_SP : trs3_pkg::S_VEL;
        end
      end
      trs3_pkg::S_SP: begin
        go = 1'b1;
        alu_req.op = trs3_pkg::ALU_SQRT;
        alu_req.a  = sum_r;
        if (fin) begin
          sp_nxt    = alu_rsp.y[31:0];
          state_nxt = (dot_r >= 64'sd0) ? trs3_pkg::S_BRK : trs3_pkg::S_CAP;
        end
      end
      trs3_pkg::S_BRK: begin
        go = 1'b1;
        alu_req.a = 64'(dsat);
        alu_req.b = 64'(dc_r);
        if (fin) begin
          tmp_nxt   = alu_rsp.y << 1;
          state_nxt = trs3_pkg::S_BRKR;
        end
      end
      trs3_pkg::S_BRKR: begin
        go = 1'b1;
        alu_req.op = trs3_pkg::ALU_SQRT;
        alu_req.a  = tmp_r;
        if (fin) begin
          if (alu_rsp.y[31:0] < vmax_r) begin
            vmax_nxt = alu_rsp.y[31:0];
          end
          state_nxt = trs3_pkg::S_CAP;
        end
      end
      trs3_pkg::S_CAP: begin
        idx_nxt = 2'd0;
        if (sp_r > vmax_r) begin
          state_nxt = (cfg_i.decel_max != 31'd0) ? trs3_pkg::S_DEC : trs3_pkg::S_SCL;
        end else begin
          state_nxt = trs3_pkg::S_LEAD1;
        end
      end
      trs3_pkg::S_DEC: begin
        go = 1'b1;
        alu_req.a = 64'(cfg_i.decel_max);
        alu_req.b = 64'(tick_r);
        if (fin) begin
          vmax_nxt  = (v2 > vmax_r) ? v2 : vmax_r;
          state_nxt = trs3_pkg::S_SCL;
        end
      end
      trs3_pkg::S_SCL: begin
        go = 1'b1;
        alu_req.a = 64'(vmag);
        alu_req.b = 64'(vmax_r);
        if (fin) begin
          tmp_nxt   = alu_rsp.y;
          state_nxt = trs3_pkg::S_SCD;
        end
      end
      trs3_pkg::S_SCD: begin
        go = 1'b1;
        alu_req.op = trs3_pkg::ALU_DIV;
        alu_req.a  = tmp_r;
        alu_req.b  = 64'(sp_r);
        if (fin) begin
          vel_nxt[idx_r] = vel_r[idx_r][31] ? -$signed(quo) : $signed(quo);
          idx_nxt        = last ? 2'd0 : idx_r + 2'd1;
          if (last) begin
            sp_nxt    = vmax_r;
            state_nxt = trs3_pkg::S_LEAD1;
          end else begin
            state_nxt = trs3_pkg::S_SCL;
          end
        end
      end
      trs3_pkg::S_LEAD1: begin
        go = 1'b1;
        alu_req.a = 64'(sp_r);
        alu_req.b = 64'(tick_r);
        if (fin) begin
          tmp_nxt   = alu_rsp.y >> 16;
          state_nxt = trs3_pkg::S_LEAD2;
        end
      end
      trs3_pkg::S_LEAD2: begin
        go = 1'b1;
        alu_req.a = tmp_r;
        alu_req.b = 64'(cfg_i.lead_factor);
        if (fin) begin
          amt_nxt   = (lead_t > 64'(dist_r)) ? dist_r : lead_t[32:0];
          idx_nxt   = 2'd0;
          state_nxt = trs3_pkg::S_STP;
        end
      end
      trs3_pkg::S_STP: begin
        go = 1'b1;
        alu_req.a = 64'(amt_r);
        alu_req.b = 64'(dirmag);
        prod_neg  = dir_r[idx_r][18];
        if (fin) begin
          stop_nxt[idx_r] = sat32(64'(pos_r[idx_r]) + (sprod >>> trs3_pkg::FRAC_BITS));
          idx_nxt         = last ? 2'd0 : idx_r + 2'd1;
          if (last) begin
            state_nxt = trs3_pkg::S_OUT;
          end
        end
      end
      trs3_pkg::S_OUT: begin
        done_o = 1'b1;
        if (out_free_i) begin
          state_nxt = trs3_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = trs3_pkg::S_IDLE;
      end
    endcase

    alu_req.start = go && !pend_r;
    if (alu_req.start) begin
      pend_nxt = 1'b1;
    end else if (fin) begin
      pend_nxt = 1'b0;
    end
  end

  assign sprod = prod_neg ? -$signed(alu_rsp.y) : $signed(alu_rsp.y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= trs3_pkg::S_IDLE;
      idx_r    <= 2'd0;
      pend_r   <= 1'b0;
      best_r   <= '0;
      stuck_r  <= '0;
      frozen_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        hold_r[i] <= '0;
        vel_r[i]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      pend_r   <= pend_nxt;
      best_r   <= best_nxt;
      stuck_r  <= stuck_nxt;
      frozen_r <= frozen_nxt;
      hold_r   <= hold_nxt;
      vel_r    <= vel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    dlt_r  <= dlt_nxt;
    rt_r   <= rt_nxt;
    tick_r <= tick_nxt;
    shf_r  <= shf_nxt;
    sum_r  <= sum_nxt;
    dist_r <= dist_nxt;
    dir_r  <= dir_nxt;
    acc_r  <= acc_nxt;
    dc_r   <= dc_nxt;
    vmax_r <= vmax_nxt;
    dot_r  <= dot_nxt;
    inc_r  <= inc_nxt;
    sp_r   <= sp_nxt;
    tmp_r  <= tmp_nxt;
    amt_r  <= amt_nxt;
    stop_r <= stop_nxt;
  end

  assign idle_o              = (state_r == trs3_pkg::S_IDLE);
  assign result_o.stop_x     = stop_r[0];
  assign result_o.stop_y     = stop_r[1];
  assign result_o.stop_z     = stop_r[2];
  assign result_o.speed      = sp_r[31] ? trs3_pkg::U31 : sp_r[30:0];
  assign result_o.remaining  = (|dist_r[32:31]) ? trs3_pkg::U31 : dist_r[30:0];
  assign result_o.stuck_time = stuck_r;

  `TRS3_ASSERT_IMP(a_alu_free, clk, rst_n, alu_req.start, !alu_rsp.busy)

endmodule

// ----- hdl/trapezoid_ramp_step_3d.sv -----
`timescale 1ns / 1ps
// Trapezoidal velocity ramp toward a 3D goal, one servo tick per input beat.
// The input channel (in_valid, in_stall, in_data) carries position, goal,
// rate and tick time; the output channel (out_valid, out_stall, out_data)
// returns one beat per input: stop point, speed, remaining distance and
// stuck time. The user writes the configuration through cfg_we, cfg_index
// and cfg_data only while the block is idle; the block itself does not
// enforce this. Unknown indexes are ignored. All arithmetic runs on one
// shared bit-serial unit for multiply, divide and square root. The time a
// tick takes depends on the sign of the rate and on whether the braking,
// speed cap and decel limit steps run. The input stalls while a tick is
// in progress; a new beat is taken as soon as the result has moved into
// the output register, even if the receiver has not taken it yet. When the
// receiver stalls with the output register full, the finished result waits
// inside and the next tick is not started until it moves. Synchronous
// reset clears the velocity, progress, freeze and hold state and restores
// the configuration registers to their defaults.
`include "trapezoid_ramp_step_3d_assert.svh"
module trapezoid_ramp_step_3d (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  trs3_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output trs3_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [trs3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [30:0]                         cfg_data
);

  trs3_pkg::cfg_t      cfg_r, cfg_nxt;
  logic                out_valid_r, out_valid_nxt;
  trs3_pkg::out_item_t out_data_r, out_data_nxt;

  logic                seq_idle;
  logic                seq_done;
  logic                out_free;
  logic                in_take;
  trs3_pkg::out_item_t seq_result;

  // The output slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !seq_idle;
  assign in_take  = in_valid && seq_idle;

  trs3_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (in_take),
    .item_i     (in_data),
    .cfg_i      (cfg_r),
    .out_free_i (out_free),
    .idle_o     (seq_idle),
    .done_o     (seq_done),
    .result_o   (seq_result)
  );

  // Register writes land in the next cycle; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (trs3_pkg::cfg_idx_t'(cfg_index))
        trs3_pkg::CFG_ACCEL:     cfg_nxt.accel_std    = cfg_data;
        trs3_pkg::CFG_DECEL:     cfg_nxt.decel_std    = cfg_data;
        trs3_pkg::CFG_CRUISE:    cfg_nxt.cruise_std   = cfg_data;
        trs3_pkg::CFG_DECEL_MAX: cfg_nxt.decel_max    = cfg_data;
        trs3_pkg::CFG_PROG_TOL:  cfg_nxt.progress_tol = cfg_data;
        trs3_pkg::CFG_LEAD:      cfg_nxt.lead_factor  = cfg_data[15:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  // The output register takes a finished result whenever its slot is free.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (seq_done && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = seq_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_std    <= trs3_pkg::ACCEL_RST;
      cfg_r.decel_std    <= trs3_pkg::DECEL_RST;
      cfg_r.cruise_std   <= trs3_pkg::CRUISE_RST;
      cfg_r.decel_max    <= trs3_pkg::DMAX_RST;
      cfg_r.progress_tol <= trs3_pkg::TOL_RST;
      cfg_r.lead_factor  <= trs3_pkg::LEAD_RST;
      out_valid_r        <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TRS3_ASSERT_NXT(a_take_busy, clk, rst_n, in_valid && !in_stall, !seq_idle)
  `TRS3_ASSERT_NXT(a_result_wait, clk, rst_n, seq_done && out_valid_r && out_stall, seq_done)

endmodule

// ----- bench/trapezoid_ramp_step_3d_tb.sv -----
`timescale 1ns / 1ps
// Each input beat carries one servo tick. A local predictor keeps its own copy
// of the velocity, progress, freeze and hold state and works out the result
// beat that each tick should produce. The scoreboard checks the results in
// order, field by field.
module trapezoid_ramp_step_3d_tb;

  localparam longint MAX31 = 64'h7FFF_FFFF;
  localparam longint MAX32 = 64'hFFFF_FFFF;
  localparam int     LAT_CYC = 1600;
  localparam longint CYC_LIMIT = 64'd8_000_000;

  // Ramp state and configuration, as seen by the predictor.
  longint r_accel, r_decel, r_cruise, r_dmax, r_tol, r_lead;
  longint vx, vy, vz, spd_now, best_d, stuck_t;
  bit     is_frozen;
  longint hx, hy, hz;

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint min64(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint max64(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint abs64(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // Floor of a signed value divided by 2^16.
  function automatic longint floor_q16(longint x);
    return x >>> 16;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic reset_ramp();
    r_accel = 65536; r_decel = 65536; r_cruise = 65536;
    r_dmax = 0; r_tol = 6554; r_lead = 256;
    vx = 0; vy = 0; vz = 0;
    spd_now = 0; best_d = 0; stuck_t = 0;
    is_frozen = 0;
    hx = 0; hy = 0; hz = 0;
  endtask

  task automatic write_ramp_reg(trs3_pkg::cfg_idx_t idx, longint val);
    case (idx)
      trs3_pkg::CFG_ACCEL:     r_accel = val & MAX31;
      trs3_pkg::CFG_DECEL:     r_decel = val & MAX31;
      trs3_pkg::CFG_CRUISE:    r_cruise = val & MAX31;
      trs3_pkg::CFG_DECEL_MAX: r_dmax = val & MAX31;
      trs3_pkg::CFG_PROG_TOL:  r_tol = val & MAX31;
      trs3_pkg::CFG_LEAD:      r_lead = val & 64'hFFFF;
      default: ;
    endcase
  endtask

  // Advances the ramp by one tick and returns the result beat it produces.
  function automatic trs3_pkg::out_item_t ramp_tick(trs3_pkg::in_item_t t);
    longint p[3], g[3], d[3], dir[3], v[3];
    longint rt, tk, dist_q, dsat, a, dc, vmax, dot, inc, sp, amt, dec, v2, m;
    longint unsigned sum, top, u;
    int s;
    trs3_pkg::out_item_t r;
    p[0] = t.pos_x; p[1] = t.pos_y; p[2] = t.pos_z;
    g[0] = t.goal_x; g[1] = t.goal_y; g[2] = t.goal_z;
    rt = t.rate;
    tk = t.tick_time;
    if (rt != 0) begin
      is_frozen = 0;
    end else begin
      if (!is_frozen) begin
        hx = p[0]; hy = p[1]; hz = p[2];
      end
      g[0] = hx; g[1] = hy; g[2] = hz;
      is_frozen = 1;
    end
    top = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = g[i] - p[i];
      if (abs64(d[i]) > top) top = abs64(d[i]);
    end
    s = (top >> 31) != 0 ? 1 : 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      u = longint'(abs64(d[i])) >> s;
      sum += u * u;
    end
    dist_q = root_floor(sum) << s;
    for (int i = 0; i < 3; i++)
      dir[i] = (dist_q != 0) ? (d[i] * 65536) / dist_q : 0;
    dsat = min64(dist_q, MAX32);
    // Progress only counts when the distance drops by more than the tolerance.
    if (best_d > dsat && best_d - dsat > r_tol) begin
      best_d = dsat;
      stuck_t = 0;
    end else begin
      best_d = max64(best_d, dsat);
      stuck_t = min64(stuck_t + tk, MAX31);
    end
    if (rt < 0) begin
      a = r_accel;
      dc = r_decel;
    end else begin
      a = min64((rt * rt * r_accel) >>> 24, MAX31);
      dc = min64((rt * rt * r_decel) >>> 24, MAX31);
    end
    vmax = min64((abs64(rt) * r_cruise) >>> 12, MAX31);
    v[0] = vx; v[1] = vy; v[2] = vz;
    dot = 0;
    for (int i = 0; i < 3; i++) dot += dir[i] * v[i];
    inc = (((dot < 0) ? dc : a) * tk) >>> 16;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = sat_s32(v[i] + floor_q16(dir[i] * inc));
      sum += longint'(v[i] * v[i]);
    end
    sp = root_floor(sum);
    if (dot >= 0) vmax = min64(vmax, root_floor(2 * dc * dsat));
    if (sp > vmax) begin
      if (r_dmax > 0) begin
        dec = (r_dmax * tk) >>> 16;
        v2 = (sp > dec) ? sp - dec : 0;
        vmax = max64(v2, vmax);
      end
      for (int i = 0; i < 3; i++) begin
        u = longint'(abs64(v[i])) * longint'(vmax);
        m = u / longint'(sp);
        v[i] = (v[i] < 0) ? -m : m;
      end
      sp = vmax;
    end
    vx = v[0]; vy = v[1]; vz = v[2];
    spd_now = sp;
    amt = ((((sp * tk) >>> 16) * r_lead) >>> 8);
    amt = min64(amt, dist_q);
    r.stop_x = sat_s32(p[0] + floor_q16(dir[0] * amt));
    r.stop_y = sat_s32(p[1] + floor_q16(dir[1] * amt));
    r.stop_z = sat_s32(p[2] + floor_q16(dir[2] * amt));
    r.speed = min64(sp, MAX31);
    r.remaining = min64(dist_q, MAX31);
    r.stuck_time = stuck_t;
    return r;
  endfunction

  // Holds the expected result beats in order and compares each arrival.
  class ramp_scoreboard;
    trs3_pkg::out_item_t pending[$];
    int                  errors;

    function void note_tick(trs3_pkg::in_item_t t);
      pending.push_back(ramp_tick(t));
    endfunction

    function void check_result(trs3_pkg::out_item_t got);
      trs3_pkg::out_item_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      w = pending.pop_front();
      if (w.stop_x !== got.stop_x || w.stop_y !== got.stop_y ||
          w.stop_z !== got.stop_z || w.speed !== got.speed ||
          w.remaining !== got.remaining || w.stuck_time !== got.stuck_time) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected stop %0d %0d %0d spd %0d rem %0d stk %0d, got %0d %0d %0d %0d %0d %0d",
                   w.stop_x, w.stop_y, w.stop_z, w.speed, w.remaining, w.stuck_time,
                   got.stop_x, got.stop_y, got.stop_z, got.speed, got.remaining,
                   got.stuck_time);
      end
    endfunction
  endclass

  logic                          clk = 0;
  logic                          rst_n = 0;
  logic                          in_valid = 0;
  logic                          in_stall;
  trs3_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 0;
  trs3_pkg::out_item_t           out_data;
  logic                          cfg_we = 0;
  logic [trs3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [30:0]                   cfg_data = '0;

  ramp_scoreboard sb;
  longint cycles = 0;
  bit     hold_off = 0;
  bit     stim_done = 0;

  always #1 clk = ~clk;

  trapezoid_ramp_step_3d i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Results are sampled at the rising edge, where the handshake takes effect.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (cycles > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver stalls at random, and holds off for a long stretch on request
  // so that the output register fills and the input stalls behind it.
  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (4000) @(negedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else if ($urandom_range(0, 3) == 0) begin
        w = $urandom_range(0, 18);
        if (w != 0) begin
          out_stall <= 1;
          repeat (w) @(negedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  // Valid stays up between back-to-back beats; it drops only for a gap.
  task automatic send_tick(trs3_pkg::in_item_t t, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
    @(negedge clk);
  endtask

  // Configuration goes in only once every result is back and the block idles.
  task automatic set_reg(trs3_pkg::cfg_idx_t idx, longint val);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LAT_CYC) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    write_ramp_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_pos(int shape);
    case (shape)
      0: return $urandom();
      1: return $signed($urandom_range(0, 400000)) - 200000;
      default: return $signed($urandom_range(0, 20000000)) - 10000000;
    endcase
  endfunction

  function automatic trs3_pkg::in_item_t rand_tick(logic [31:0] bx, logic [31:0] by,
                                                   logic [31:0] bz, logic [31:0] gx,
                                                   logic [31:0] gy, logic [31:0] gz);
    trs3_pkg::in_item_t t;
    int k;
    k = $urandom_range(0, 19);
    t.pos_x = bx; t.pos_y = by; t.pos_z = bz;
    t.goal_x = gx; t.goal_y = gy; t.goal_z = gz;
    if (k < 2) t.rate = 0;
    else if (k < 5) t.rate = -$signed({1'b0, 15'($urandom_range(1, 32767))});
    else if (k < 7) t.rate = 16'($urandom());
    else t.rate = 16'($urandom_range(1024, 8192));
    t.tick_time = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                             : 16'($urandom_range(0, 2000));
    return t;
  endfunction

  task automatic random_phase(int n);
    logic [31:0] px, py, pz, gx, gy, gz;
    int shape;
    for (int j = 0; j < n; j++) begin
      // Mostly coherent moves toward a goal that changes now and then.
      if (j % 20 == 0) begin
        shape = $urandom_range(0, 5);
        shape = (shape == 0) ? 0 : (shape < 3 ? 2 : 1);
        px = rand_pos(shape); py = rand_pos(shape); pz = rand_pos(shape);
        gx = rand_pos(shape); gy = rand_pos(shape); gz = rand_pos(shape);
      end
      if ($urandom_range(0, 9) == 0) begin
        px = $urandom(); py = $urandom(); pz = $urandom();
      end else begin
        px = px + ($signed(gx - px) >>> $urandom_range(2, 6));
        py = py + ($signed(gy - py) >>> $urandom_range(2, 6));
        pz = pz + ($signed(gz - pz) >>> $urandom_range(2, 6));
      end
      if (j == n / 2 && n > 50) hold_off = 1;
      send_tick(rand_tick(px, py, pz, gx, gy, gz), hold_off || (j % 37 < 6));
    end
  endtask

  initial begin
    trs3_pkg::in_item_t t;
    sb = new();
    reset_ramp();
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed ticks: extremes of every field, freeze, zero distance,
    // huge distance, negative and extreme rates, zero tick time.
    t = '{32'sd0, 32'sd0, 32'sd0, 32'sd655360, 32'sd0, 32'sd0, 16'sd4096, 16'd655};
    for (int j = 0; j < 4; j++) send_tick(t, 0);
    t.rate = 0; send_tick(t, 0);
    t.pos_x = 32'sd1000; send_tick(t, 0);
    t.goal_x = 32'sd1000; t.rate = 16'sd4096; send_tick(t, 0);
    t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sh7FFF, 16'hFFFF};
    send_tick(t, 0); send_tick(t, 0);
    t = '{32'h7FFF_FFFF, 32'h8000_0000, 32'sd0,
          32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'sh8000, 16'd0};
    send_tick(t, 0);
    t.tick_time = 16'hFFFF; send_tick(t, 0);
    t.rate = -16'sd1; send_tick(t, 0);
    t = '{32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 16'sd1, 16'd1};
    send_tick(t, 0);
    t = '{32'sd0, 32'sd0, 32'sd0, -32'sd65536, 32'sd65536, 32'sd1, 16'sd4096, 16'h5555};
    send_tick(t, 0);
    t.tick_time = 16'hAAAA; t.rate = 16'sh5555; send_tick(t, 0);
    t.rate = 16'shAAAA; send_tick(t, 0);

    random_phase(200);
    set_reg(trs3_pkg::CFG_ACCEL, 64'h7FFF_FFFF);
    set_reg(trs3_pkg::CFG_DECEL, 64'h7FFF_FFFF);
    set_reg(trs3_pkg::CFG_CRUISE, 64'h7FFF_FFFF);
    set_reg(trs3_pkg::CFG_DECEL_MAX, 64'd3000000);
    set_reg(trs3_pkg::CFG_LEAD, 64'hFFFF);
    random_phase(200);
    set_reg(trs3_pkg::CFG_ACCEL, 64'd0);
    set_reg(trs3_pkg::CFG_DECEL, 64'd0);
    set_reg(trs3_pkg::CFG_CRUISE, 64'd0);
    set_reg(trs3_pkg::CFG_DECEL_MAX, 64'h7FFF_FFFF);
    set_reg(trs3_pkg::CFG_PROG_TOL, 64'd0);
    set_reg(trs3_pkg::CFG_LEAD, 64'd0);
    random_phase(150);
    set_reg(trs3_pkg::CFG_ACCEL, 64'd400000);
    set_reg(trs3_pkg::CFG_DECEL, 64'd800000);
    set_reg(trs3_pkg::CFG_CRUISE, 64'd2000000);
    set_reg(trs3_pkg::CFG_DECEL_MAX, 64'd200000);
    set_reg(trs3_pkg::CFG_PROG_TOL, 64'h7FFF_FFFF);
    set_reg(trs3_pkg::CFG_LEAD, 64'd512);
    random_phase(200);
    set_reg(trs3_pkg::CFG_DECEL_MAX, 64'd1);
    set_reg(trs3_pkg::CFG_PROG_TOL, 64'd6554);
    set_reg(trs3_pkg::CFG_LEAD, 64'h5555);
    random_phase(230);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LAT_CYC) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
